@@ rtl/core/sacl_pkg.sv @@
`timescale 1ns / 1ps

package sacl_pkg;

    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 32;
    localparam int STAMP_W = 32;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-1:0] REG_REPLACE_MODE = 3'd0;

    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_LRU  = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  tag;
        logic [STAMP_W-1:0] stamp;
    } line_t;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_MOD   = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

@@ rtl/core/sacl_ram.sv @@
`timescale 1ns / 1ps

module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/set_associative_cache_lookup.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Beat contents
// s_        in         s_address
// m_        out        m_hit, m_way_used, m_hit_count, m_miss_count
// apb       in/out     replace_mode at byte address 0
//
// When NUM_SETS is not a power of two, a reciprocal multiplication finds the set.
// The line memory, with one read and one write port, is read one way per cycle to
// find hit, free way and oldest stamp. After reset a clearing pass over all
// 2**(set bits + way bits) line addresses zeroes the memories; s_ready stays low
// meanwhile. The result sits in an output register, so a new access is taken
// while the previous result waits on m_ready.

module set_associative_cache_lookup
    import sacl_pkg::*;
#(
    parameter int NUM_SETS = 16,
    parameter int WAYS     = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [ADDR_W-1:0]  s_address,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic [1:0]         m_way_used,
    output logic [COUNT_W-1:0] m_hit_count,
    output logic [COUNT_W-1:0] m_miss_count,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int  SET_W     = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
    localparam int  WAY_W     = WAYS > 1 ? $clog2(WAYS) : 1;
    localparam int  WCNT_W    = $clog2(WAYS + 1);
    localparam int  LA_W      = SET_W + WAY_W;
    localparam int  LINE_D    = 2 ** LA_W;
    localparam int  SET_D     = 2 ** SET_W;
    localparam int  LINE_W    = $bits(line_t);
    localparam bit  SETS_POW2 = (NUM_SETS & (NUM_SETS - 1)) == 0;
    localparam logic [2*ADDR_W-1:0] RECIP_WIDE =
        ((2*ADDR_W)'(1) << ADDR_W) / (2*ADDR_W)'(NUM_SETS);
    localparam logic [ADDR_W-1:0]   RECIP      = RECIP_WIDE[ADDR_W-1:0];

    state_t state_reg, state_next;

    logic                mode_reg;
    logic [LA_W-1:0]     clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [SET_W-1:0]    set_reg, set_next;
    logic [ADDR_W-1:0]   rem_reg, rem_next;
    logic [2*ADDR_W-1:0] prod_reg, prod_next;
    logic [1:0]          mod_step_reg, mod_step_next;
    logic [WCNT_W-1:0]   issue_cnt_reg, issue_cnt_next;
    logic                eval_vld_reg, eval_vld_next;
    logic [WAY_W-1:0]    eval_way_reg, eval_way_next;

    logic               hit_found_reg, hit_found_next;
    logic [WAY_W-1:0]   hit_way_reg, hit_way_next;
    logic               inv_found_reg, inv_found_next;
    logic [WAY_W-1:0]   inv_way_reg, inv_way_next;
    logic [WAY_W-1:0]   min_way_reg, min_way_next;
    logic [STAMP_W-1:0] min_stamp_reg, min_stamp_next;
    logic [WAY_W-1:0]   fifo_ptr_reg, fifo_ptr_next;
    logic [STAMP_W-1:0] fifo_stamp_reg, fifo_stamp_next;

    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic [COUNT_W-1:0] hit_total_reg, hit_total_next;
    logic [COUNT_W-1:0] miss_total_reg, miss_total_next;

    logic               m_valid_reg, m_valid_next;
    logic               m_hit_reg, m_hit_next;
    logic [1:0]         m_way_used_reg, m_way_used_next;
    logic [COUNT_W-1:0] m_hit_count_reg, m_hit_count_next;
    logic [COUNT_W-1:0] m_miss_count_reg, m_miss_count_next;

    logic               line_we, line_re;
    logic [LA_W-1:0]    line_waddr, line_raddr;
    line_t              line_wdata, line_rdata;
    logic               fifo_we, fifo_re;
    logic [SET_W-1:0]   fifo_waddr;
    logic [WAY_W-1:0]   fifo_wdata, fifo_rdata;

    logic               out_free;
    logic               cfg_write;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr == REG_REPLACE_MODE) ? PDATA_W'(mode_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_LRU;
        end else if (cfg_write && paddr == REG_REPLACE_MODE) begin
            mode_reg <= pwdata[0];
        end
    end

    sacl_ram #(.WIDTH(LINE_W), .DEPTH(LINE_D)) u_line_ram (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .re    (line_re),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    sacl_ram #(.WIDTH(WAY_W), .DEPTH(SET_D)) u_fifo_ram (
        .aclk  (aclk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (fifo_wdata),
        .re    (fifo_re),
        .raddr (set_reg),
        .rdata (fifo_rdata)
    );

    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        logic [WAY_W-1:0]   way;
        logic [STAMP_W-1:0] wr_stamp;
        logic               do_write;
        logic               do_touch;

        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        addr_next         = addr_reg;
        set_next          = set_reg;
        rem_next          = rem_reg;
        prod_next         = prod_reg;
        mod_step_next     = mod_step_reg;
        issue_cnt_next    = issue_cnt_reg;
        eval_vld_next     = 1'b0;
        eval_way_next     = eval_way_reg;
        hit_found_next    = hit_found_reg;
        hit_way_next      = hit_way_reg;
        inv_found_next    = inv_found_reg;
        inv_way_next      = inv_way_reg;
        min_way_next      = min_way_reg;
        min_stamp_next    = min_stamp_reg;
        fifo_ptr_next     = fifo_ptr_reg;
        fifo_stamp_next   = fifo_stamp_reg;
        stamp_next        = stamp_reg;
        hit_total_next    = hit_total_reg;
        miss_total_next   = miss_total_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_hit_next        = m_hit_reg;
        m_way_used_next   = m_way_used_reg;
        m_hit_count_next  = m_hit_count_reg;
        m_miss_count_next = m_miss_count_reg;

        line_we    = 1'b0;
        line_waddr = {set_reg, hit_way_reg};
        line_wdata = '0;
        line_re    = 1'b0;
        line_raddr = {set_reg, issue_cnt_reg[WAY_W-1:0]};
        fifo_we    = 1'b0;
        fifo_waddr = set_reg;
        fifo_wdata = '0;
        fifo_re    = 1'b0;

        way      = hit_way_reg;
        wr_stamp = stamp_reg;
        do_write = 1'b0;
        do_touch = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                line_we       = 1'b1;
                line_waddr    = clr_addr_reg;
                fifo_we       = 1'b1;
                fifo_waddr    = clr_addr_reg[LA_W-1:WAY_W];
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LA_W'(LINE_D - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    addr_next      = s_address;
                    set_next       = SET_W'(s_address & ADDR_W'(NUM_SETS - 1));
                    mod_step_next  = '0;
                    issue_cnt_next = '0;
                    hit_found_next = 1'b0;
                    inv_found_next = 1'b0;
                    state_next     = SETS_POW2 ? ST_SCAN : ST_MOD;
                end
            end
            ST_MOD: begin
                mod_step_next = mod_step_reg + 1'b1;
                if (mod_step_reg == 2'd0) begin
                    prod_next = (2*ADDR_W)'(addr_reg) * (2*ADDR_W)'(RECIP);
                end else if (mod_step_reg == 2'd1) begin
                    rem_next = ADDR_W'(prod_reg[2*ADDR_W-1:ADDR_W] * ADDR_W'(NUM_SETS));
                end else if (mod_step_reg == 2'd2) begin
                    rem_next = addr_reg - rem_reg;
                end else begin
                    if (rem_reg >= ADDR_W'(NUM_SETS)) begin
                        set_next = SET_W'(rem_reg - ADDR_W'(NUM_SETS));
                    end else begin
                        set_next = SET_W'(rem_reg);
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (issue_cnt_reg < WCNT_W'(WAYS)) begin
                    line_re        = 1'b1;
                    fifo_re        = (issue_cnt_reg == '0);
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    eval_vld_next  = 1'b1;
                    eval_way_next  = issue_cnt_reg[WAY_W-1:0];
                end
                if (eval_vld_reg) begin
                    fifo_ptr_next = fifo_rdata;
                    if (!hit_found_reg && line_rdata.valid && line_rdata.tag == addr_reg) begin
                        hit_found_next = 1'b1;
                        hit_way_next   = eval_way_reg;
                    end
                    if (!inv_found_reg && !line_rdata.valid) begin
                        inv_found_next = 1'b1;
                        inv_way_next   = eval_way_reg;
                    end
                    if (eval_way_reg == '0 || line_rdata.stamp < min_stamp_reg) begin
                        min_way_next   = eval_way_reg;
                        min_stamp_next = line_rdata.stamp;
                    end
                    if (eval_way_reg == fifo_rdata) begin
                        fifo_stamp_next = line_rdata.stamp;
                    end
                    if (issue_cnt_reg == WCNT_W'(WAYS)) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (hit_found_reg) begin
                    way      = hit_way_reg;
                    do_write = (mode_reg == MODE_LRU);
                    do_touch = (mode_reg == MODE_LRU);
                end else if (inv_found_reg) begin
                    way      = inv_way_reg;
                    do_write = 1'b1;
                    do_touch = (mode_reg == MODE_LRU);
                    wr_stamp = (mode_reg == MODE_LRU) ? stamp_reg : '0;
                end else if (mode_reg == MODE_LRU) begin
                    way      = min_way_reg;
                    do_write = 1'b1;
                    do_touch = 1'b1;
                end else begin
                    way      = fifo_ptr_reg;
                    do_write = 1'b1;
                    wr_stamp = fifo_stamp_reg;
                end
                if (out_free) begin
                    line_we    = do_write;
                    line_waddr = {set_reg, way};
                    line_wdata = '{valid: 1'b1, tag: addr_reg, stamp: wr_stamp};
                    fifo_we    = !hit_found_reg && !inv_found_reg && (mode_reg == MODE_FIFO);
                    fifo_wdata = (fifo_ptr_reg == WAY_W'(WAYS - 1)) ? '0
                                                                    : fifo_ptr_reg + 1'b1;
                    if (do_touch) begin
                        stamp_next = stamp_reg + 1'b1;
                    end
                    if (hit_found_reg) begin
                        if (hit_total_reg != '1) begin
                            hit_total_next = hit_total_reg + 1'b1;
                        end
                    end else if (miss_total_reg != '1) begin
                        miss_total_next = miss_total_reg + 1'b1;
                    end
                    m_valid_next      = 1'b1;
                    m_hit_next        = hit_found_reg;
                    m_way_used_next   = 2'(way);
                    m_hit_count_next  = hit_total_next;
                    m_miss_count_next = miss_total_next;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            eval_vld_reg   <= 1'b0;
            stamp_reg      <= '0;
            hit_total_reg  <= '0;
            miss_total_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            eval_vld_reg   <= eval_vld_next;
            stamp_reg      <= stamp_next;
            hit_total_reg  <= hit_total_next;
            miss_total_reg <= miss_total_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg         <= addr_next;
        set_reg          <= set_next;
        rem_reg          <= rem_next;
        prod_reg         <= prod_next;
        mod_step_reg     <= mod_step_next;
        issue_cnt_reg    <= issue_cnt_next;
        eval_way_reg     <= eval_way_next;
        hit_found_reg    <= hit_found_next;
        hit_way_reg      <= hit_way_next;
        inv_found_reg    <= inv_found_next;
        inv_way_reg      <= inv_way_next;
        min_way_reg      <= min_way_next;
        min_stamp_reg    <= min_stamp_next;
        fifo_ptr_reg     <= fifo_ptr_next;
        fifo_stamp_reg   <= fifo_stamp_next;
        m_hit_reg        <= m_hit_next;
        m_way_used_reg   <= m_way_used_next;
        m_hit_count_reg  <= m_hit_count_next;
        m_miss_count_reg <= m_miss_count_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_way_used   = m_way_used_reg;
    assign m_hit_count  = m_hit_count_reg;
    assign m_miss_count = m_miss_count_reg;

endmodule

@@ rtl/core/sacl_checker.sv @@
`timescale 1ns / 1ps

module sacl_checker
    import sacl_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_hit,
    input logic [1:0]         m_way_used,
    input logic [COUNT_W-1:0] m_hit_count,
    input logic [COUNT_W-1:0] m_miss_count
);

    logic [COUNT_W-1:0] last_hit_reg;
    logic [COUNT_W-1:0] last_miss_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_hit_reg  <= '0;
            last_miss_reg <= '0;
        end else if (m_valid && m_ready) begin
            last_hit_reg  <= m_hit_count;
            last_miss_reg <= m_miss_count;
        end
    end

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_way_used)
            && $stable(m_hit_count) && $stable(m_miss_count))
        else $error("result beat changed while stalled");

    // An accepted access moves the control out of idle, so the input is not ready right after a beat.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accepted beat");

    // The count that matches the outcome includes this access.
    a_count_matches_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_hit ? (m_hit_count == '0) : (m_miss_count == '0)) |-> 1'b0)
        else $error("outcome not reflected in its count");

    // Running counts never go down from one result beat to the next.
    a_counts_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |-> m_hit_count >= last_hit_reg && m_miss_count >= last_miss_reg)
        else $error("running count decreased");

endmodule

bind set_associative_cache_lookup sacl_checker u_sacl_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_hit        (m_hit),
    .m_way_used   (m_way_used),
    .m_hit_count  (m_hit_count),
    .m_miss_count (m_miss_count)
);

@@ test/set_associative_cache_lookup_test.sv @@
`timescale 1ns / 1ps

module set_associative_cache_lookup_test;
    import sacl_pkg::*;

    localparam int NUM_SETS = 16;
    localparam int WAYS = 4;
    localparam int DRAIN_CYCLES = WAYS + 12;
    localparam int PHASE_ITEMS = 156;
    localparam int RANDOM_PHASES = 8;
    localparam int TAG_POOL = 6;
    localparam logic [PADDR_W-1:0] UNMAPPED_REG_ADDR = 3'd4;

    typedef struct packed {
        logic               hit;
        logic [1:0]         way;
        logic [COUNT_W-1:0] hits;
        logic [COUNT_W-1:0] misses;
    } lookup_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [ADDR_W-1:0]  s_address = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_hit;
    logic [1:0]         m_way_used;
    logic [COUNT_W-1:0] m_hit_count;
    logic [COUNT_W-1:0] m_miss_count;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    set_associative_cache_lookup #(
        .NUM_SETS(NUM_SETS),
        .WAYS    (WAYS)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_address   (s_address),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_way_used  (m_way_used),
        .m_hit_count (m_hit_count),
        .m_miss_count(m_miss_count),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Shadow copy of the tag store and its replacement state.
    logic [ADDR_W-1:0]  shadow_tag   [NUM_SETS][WAYS];
    logic               shadow_valid [NUM_SETS][WAYS];
    logic [STAMP_W-1:0] shadow_stamp [NUM_SETS][WAYS];
    int                 shadow_fifo  [NUM_SETS];
    logic [STAMP_W-1:0] shadow_clock = '0;
    logic [COUNT_W-1:0] shadow_hits = '0;
    logic [COUNT_W-1:0] shadow_misses = '0;
    logic               cfg_mode = MODE_LRU;

    logic [ADDR_W-1:0] address_q[$];
    lookup_result_t    predicted_lookups[$];

    logic s_fire_q = 1'b0;
    int   tx_mode = 0;
    int   rx_mode = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    logic [15:0] rx_pattern = '1;
    int   rx_phase = 0;

    int fail_count = 0;
    int results_checked = 0;
    int hit_results = 0;
    int mode_writes = 0;

    logic [ADDR_W-5:0] tag_pool [TAG_POOL];
    logic [3:0]        set_mask = 4'hF;

    initial begin
        for (int s = 0; s < NUM_SETS; s++) begin
            shadow_fifo[s] = 0;
            for (int w = 0; w < WAYS; w++) begin
                shadow_tag[s][w] = '0;
                shadow_valid[s][w] = 1'b0;
                shadow_stamp[s][w] = '0;
            end
        end
    end

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void stamp_line(input int set_idx, input int way);
        if (cfg_mode == MODE_LRU) begin
            shadow_stamp[set_idx][way] = shadow_clock;
            shadow_clock = shadow_clock + 1'b1;
        end
    endfunction

    function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] addr);
        int             set_idx;
        int             way;
        int             w;
        bit             found;
        bit             free_found;
        lookup_result_t r;
        set_idx = addr % NUM_SETS;
        way = 0;
        found = 1'b0;
        free_found = 1'b0;
        for (w = 0; w < WAYS; w++) begin
            if (!found && shadow_valid[set_idx][w] && shadow_tag[set_idx][w] == addr) begin
                found = 1'b1;
                way = w;
            end
        end
        if (found) begin
            if (shadow_hits != '1) shadow_hits = shadow_hits + 1'b1;
            stamp_line(set_idx, way);
        end else begin
            for (w = 0; w < WAYS; w++) begin
                if (!free_found && !shadow_valid[set_idx][w]) begin
                    free_found = 1'b1;
                    way = w;
                end
            end
            if (!free_found) begin
                if (cfg_mode == MODE_FIFO) begin
                    way = shadow_fifo[set_idx] % WAYS;
                    shadow_fifo[set_idx] = (way + 1) % WAYS;
                end else begin
                    way = 0;
                    for (w = 1; w < WAYS; w++) begin
                        if (shadow_stamp[set_idx][w] < shadow_stamp[set_idx][way]) way = w;
                    end
                end
            end
            shadow_valid[set_idx][way] = 1'b1;
            shadow_tag[set_idx][way] = addr;
            stamp_line(set_idx, way);
            if (shadow_misses != '1) shadow_misses = shadow_misses + 1'b1;
        end
        r.hit = found;
        r.way = way[1:0];
        r.hits = shadow_hits;
        r.misses = shadow_misses;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] expected,
                                   input logic [63:0] actual);
        $display("%0t: mismatch on %s, expected 0x%0h, got 0x%0h", $time, field, expected,
                 actual);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        lookup_result_t want;
        if (!aresetn) begin
            s_fire_q <= 1'b0;
        end else begin
            s_fire_q <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                predicted_lookups.push_back(predict_lookup(s_address));
            end
            if (m_valid && m_ready) begin
                if (predicted_lookups.size() == 0) begin
                    $display("%0t: result beat with no lookup outstanding, hit %0b way %0d",
                             $time, m_hit, m_way_used);
                    fail_count++;
                end else begin
                    want = predicted_lookups.pop_front();
                    results_checked++;
                    if (want.hit) hit_results++;
                    if (m_hit !== want.hit)
                        report_mismatch("hit", 64'(want.hit), 64'(m_hit));
                    if (m_way_used !== want.way)
                        report_mismatch("way_used", 64'(want.way), 64'(m_way_used));
                    if (m_hit_count !== want.hits)
                        report_mismatch("hit_count", 64'(want.hits), 64'(m_hit_count));
                    if (m_miss_count !== want.misses)
                        report_mismatch("miss_count", 64'(want.misses), 64'(m_miss_count));
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_fire_q) begin
            s_valid <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            s_valid <= 1'b0;
        end else if (address_q.size() != 0) begin
            s_valid <= 1'b1;
            s_address <= address_q.pop_front();
            if (burst_left > 1) begin
                burst_left <= burst_left - 1;
            end else begin
                case (tx_mode)
                    0: begin
                        burst_left <= 1000;
                        gap_left <= 0;
                    end
                    1: begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= $urandom_range(0, 3);
                    end
                    default: begin
                        burst_left <= $urandom_range(1, 4);
                        gap_left <= $urandom_range(0, 20);
                    end
                endcase
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (rx_phase == 0) begin
            case (rx_mode)
                0: rx_pattern <= '1;
                1: rx_pattern <= 16'($urandom() | $urandom());
                default: rx_pattern <= 16'($urandom() & $urandom());
            endcase
        end
        m_ready <= (rx_phase == 0) ? (rx_mode == 0 || $urandom_range(0, 1) == 1)
                                   : rx_pattern[rx_phase];
        rx_phase <= (rx_phase + 1) % 16;
    end

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (addr == REG_REPLACE_MODE) cfg_mode = data[0];
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        data = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_policy(input logic mode);
        logic [PDATA_W-1:0] readback;
        apb_write(REG_REPLACE_MODE, {{(PDATA_W-1){1'b0}}, mode});
        mode_writes++;
        apb_read(REG_REPLACE_MODE, readback);
        if (readback[0] !== mode)
            report_mismatch("replace_mode readback", 64'(mode), 64'(readback[0]));
    endtask

    task automatic drain_lookups();
        while (address_q.size() != 0 || s_valid || predicted_lookups.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [ADDR_W-1:0] random_address();
        int pick;
        logic [3:0] set_bits;
        pick = $urandom_range(0, 99);
        set_bits = 4'($urandom_range(0, 15));
        if (pick < 10) return $urandom();
        if (pick < 14) return ($urandom_range(0, 1) == 1) ? {28'hFFFFFFF, set_bits}
                                                          : {28'h0, set_bits};
        return {tag_pool[$urandom_range(0, TAG_POOL - 1)], set_bits & set_mask};
    endfunction

    initial begin
        logic [ADDR_W-1:0] lru_warmup[] = '{32'h0, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFF0, 32'h10,
                                            32'h20, 32'h10, 32'h30, 32'h0, 32'hAAAAAAAA,
                                            32'h55555555};
        logic [ADDR_W-1:0] fifo_wrap[] = '{32'h40, 32'h50, 32'h60, 32'h70, 32'h80, 32'h30};
        logic [ADDR_W-1:0] lru_leftover[] = '{32'h90, 32'h40};
        logic [PDATA_W-1:0] readback;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The policy register comes out of reset in LRU mode.
        apb_read(REG_REPLACE_MODE, readback);
        if (readback[0] !== MODE_LRU) report_mismatch("replace_mode at reset", 64'(MODE_LRU),
                                                      64'(readback[0]));
        foreach (lru_warmup[i]) address_q.push_back(lru_warmup[i]);
        drain_lookups();

        // A write to an unmapped register must leave the policy alone.
        apb_write(UNMAPPED_REG_ADDR, '0);
        apb_read(REG_REPLACE_MODE, readback);
        if (readback[0] !== MODE_LRU) report_mismatch("replace_mode after unmapped write",
                                                      64'(MODE_LRU), 64'(readback[0]));

        set_policy(MODE_FIFO);
        foreach (fifo_wrap[i]) address_q.push_back(fifo_wrap[i]);
        drain_lookups();
        set_policy(MODE_LRU);
        foreach (lru_leftover[i]) address_q.push_back(lru_leftover[i]);
        drain_lookups();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_policy((phase % 3 == 1 || phase == 4) ? MODE_FIFO : MODE_LRU);
            tx_mode = phase % 3;
            rx_mode = (phase / 3 + phase) % 3;
            set_mask = ($urandom_range(0, 1) == 1) ? 4'hF : 4'h3;
            foreach (tag_pool[i]) tag_pool[i] = (ADDR_W-4)'($urandom());
            for (int n = 0; n < PHASE_ITEMS; n++) address_q.push_back(random_address());
            drain_lookups();
        end

        $display("Checked %0d lookups (%0d hits, %0d misses) over %0d policy writes,",
                 results_checked, hit_results, results_checked - hit_results, mode_writes);
        $display("with FIFO and LRU replacement under varied input gaps and output stalls.");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
